### src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; clock and reset names follow the house style
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define SPQ_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("spq assertion failed");

// concurrent assertion on the default clk / arst_n pair
`define SPQ_ASSERT_CLK(lbl, prop) `SPQ_ASSERT(lbl, clk, arst_n, prop)

`endif

### src/spq_pkg.sv
// shared types and constants of the stable priority queue
// no dependencies; imported by every module of the block except spq_ram
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int FILL_W = 5;

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;

	// command codes carried on s_tuser
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// stored entry, same layout as one slot word
	typedef struct packed {
		logic [15:0] code;
		logic [7:0]  kind;
		logic [7:0]  prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// one finished result from the sequencer
	typedef struct packed {
		status_t           status;
		entry_t            head;
		logic [FILL_W-1:0] fill;
	} result_t;

endpackage

### src/spq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module spq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### src/spq_ctrl.sv
// sequencer of the priority queue: circular slot store, one compare per step
// depends on spq_pkg and spq_ram
module spq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_cmd,
	input  spq_pkg::entry_t  in_entry,
	output logic             res_valid,
	input  logic             res_ready,
	output spq_pkg::result_t res
);
	import spq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_PLACE,
		S_POPRD,
		S_POPDAT,
		S_OUT
	} state_t;

	state_t  state_q;
	addr_t   head_q;
	cnt_t    occ_q;
	addr_t   k_q;
	entry_t  new_q;
	result_t res_q;

	logic   wr_en;
	addr_t  wr_addr;
	entry_t wr_data;
	addr_t  rd_addr;
	entry_t rd_data;
	logic   accept;
	logic   greater;

	// physical slot of logical position off behind the head
	function automatic addr_t phys(addr_t base, logic [AW:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + off;
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_OUT);
	assign res       = res_q;

	// the single compare: stored entry ranks behind the new one
	assign greater = (rd_data.prio > new_q.prio);

	// ram port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = phys(head_q, {1'b0, k_q} + 1'b1);
		wr_data = new_q;
		rd_addr = head_q;
		case (state_q)
			S_RD: begin
				rd_addr = phys(head_q, {1'b0, k_q});
			end
			S_CMP: begin
				// prefetch the next lower position while comparing this one
				rd_addr = phys(head_q, {1'b0, k_q - 1'b1});
				wr_en   = 1'b1;
				wr_data = greater ? rd_data : new_q;
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = head_q;
			end
			default: begin
			end
		endcase
	end

	spq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// sequencer state, queue bookkeeping and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_q        <= in_entry;
						res_q.head   <= '0;
						res_q.fill   <= FILL_W'(occ_q);
						if (in_cmd == CMD_INSERT) begin
							if (occ_q == cnt_t'(DEPTH)) begin
								res_q.status <= ST_FULL;
								state_q      <= S_OUT;
							end else if (occ_q == '0) begin
								state_q <= S_PLACE;
							end else begin
								k_q     <= AW'(occ_q - 1'b1);
								state_q <= S_RD;
							end
						end else begin
							if (occ_q == '0) begin
								res_q.status <= ST_EMPTY;
								state_q      <= S_OUT;
							end else begin
								state_q <= S_POPRD;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (greater) begin
						if (k_q == '0) begin
							state_q <= S_PLACE;
						end else begin
							k_q <= k_q - 1'b1;
						end
					end else begin
						occ_q        <= occ_q + 1'b1;
						res_q.status <= ST_INSERTED;
						res_q.fill   <= FILL_W'(cnt_t'(occ_q + 1'b1));
						state_q      <= S_OUT;
					end
				end
				S_PLACE: begin
					occ_q        <= occ_q + 1'b1;
					res_q.status <= ST_INSERTED;
					res_q.fill   <= FILL_W'(cnt_t'(occ_q + 1'b1));
					state_q      <= S_OUT;
				end
				S_POPRD: begin
					state_q <= S_POPDAT;
				end
				S_POPDAT: begin
					head_q       <= phys(head_q, (AW+1)'(1));
					occ_q        <= occ_q - 1'b1;
					res_q.status <= ST_POPPED;
					res_q.head   <= rd_data;
					res_q.fill   <= FILL_W'(cnt_t'(occ_q - 1'b1));
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/stable_priority_queue.sv
// top level of the stable priority queue: stream ports and output register
// depends on spq_pkg, spq_ctrl and spq_ram
//
//  channel | dir | tdata (low bit up)                         | tuser
//  s_*     | in  | entry_code, entry_kind, entry_priority     | cmd
//  m_*     | out | head_code, head_kind, head_priority, fill  | status
//
// insert: the sequencer steps past every stored entry with a greater
//   priority value; the slot ram port reads, compares and shifts one per cycle
// insert into an empty queue: placed at the head with no compare
// pop: waits on the registered ram read; full insert or empty pop: no ram access
// reset clears count, head pointer, sequencer state and output valid; slot contents stay undefined
// a result waits in the output register; the sequencer holds until it drains
module stable_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // entry_code[15:0], entry_kind[23:16], entry_priority[31:24]
	input  logic [0:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // head_code[15:0], head_kind[23:16], head_priority[31:24],
	                               // fill_count[36:32], zero pad[39:37]
	output logic [1:0]  m_tuser    // status
);
	import spq_pkg::*;

	entry_t  in_entry;
	logic    res_valid;
	logic    res_ready;
	result_t res;
	logic    m_valid_q;
	result_t m_res_q;

	// unpack the input beat
	assign in_entry.code = s_tdata[15:0];
	assign in_entry.kind = s_tdata[23:16];
	assign in_entry.prio = s_tdata[31:24];

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser[0]),
		.in_entry (in_entry),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register, loads when empty or being drained
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	// pack the output beat
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, m_res_q.fill, m_res_q.head.prio, m_res_q.head.kind,
		m_res_q.head.code};
	assign m_tuser  = m_res_q.status;

endmodule

### src/spq_checker.sv
// port-level checks of the stable priority queue, bound to the top level
// depends on spq_pkg and assert_macros.svh
`include "assert_macros.svh"

module spq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import spq_pkg::*;

	// an accepted input beat makes the block busy
	`SPQ_ASSERT_CLK(a_in_busy, s_tvalid && s_tready |=> !s_tready)

	// a stalled result beat holds
	`SPQ_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// only a pop with data carries head fields
	`SPQ_ASSERT_CLK(a_head_zero, m_tvalid && (m_tuser != ST_POPPED) |-> (m_tdata[31:0] == 32'd0))

	// a dropped insert reports a full queue
	`SPQ_ASSERT_CLK(a_full_count, m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[36:32] == FILL_W'(DEPTH)))

	// an empty pop reports an empty queue
	`SPQ_ASSERT_CLK(a_empty_count, m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[36:32] == '0))

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

### bench/tb_stable_priority_queue.sv
// self-checking bench for stable_priority_queue: directed table, then random phases
// depends on spq_pkg and the stable_priority_queue rtl; carries its own queue predictor
`timescale 1ns / 100ps

module tb_stable_priority_queue;
	import spq_pkg::*;

	localparam int CLK_HALF   = 4;
	localparam int LONG_STALL = 200;
	localparam int SEG_ITEMS  = 160;
	localparam int NUM_SEGS   = 12;
	localparam int NUM_ROWS   = 25;

	// one expected result, same fields as the m side
	typedef struct packed {
		status_t     status;
		logic [15:0] code;
		logic [7:0]  kind;
		logic [7:0]  prio;
		logic [4:0]  fill;
	} queue_res_t;

	// one row of directed stimulus, with an optional typed-in result
	typedef struct packed {
		logic        cmd;
		logic [15:0] code;
		logic [7:0]  kind;
		logic [7:0]  prio;
		logic        fixed;
		queue_res_t  res;
	} stim_row_t;

	localparam queue_res_t NO_RES = '{ST_INSERTED, 16'h0, 8'h0, 8'h0, 5'd0};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	// predictor state
	entry_t      model_slots [DEPTH];
	int          model_count = 0;
	queue_res_t  awaited_results [$];
	queue_res_t  predicted;
	int unsigned mismatches = 0;

	// sequencing flags shared with the receiver and the input monitor
	logic        no_idle = 1'b0;
	logic        long_stall_req = 1'b0;
	logic        row_fixed = 1'b0;
	queue_res_t  row_res = NO_RES;

	stim_row_t   dir_rows [NUM_ROWS];

	stable_priority_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #(CLK_HALF) clk = ~clk;

	// sorted-list queue: insert behind equal priorities, pop from the head
	function automatic queue_res_t apply_queue_op(logic cmd, logic [15:0] code,
			logic [7:0] kind, logic [7:0] prio);
		queue_res_t r;
		int pos;
		r = NO_RES;
		if (cmd == CMD_INSERT) begin
			if (model_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < model_count && model_slots[pos].prio <= prio)
					pos++;
				for (int i = model_count; i > pos; i--)
					model_slots[i] = model_slots[i-1];
				model_slots[pos] = '{code, kind, prio};
				model_count++;
				r.status = ST_INSERTED;
			end
		end else if (model_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.status = ST_POPPED;
			r.code   = model_slots[0].code;
			r.kind   = model_slots[0].kind;
			r.prio   = model_slots[0].prio;
			for (int i = 1; i < model_count; i++)
				model_slots[i-1] = model_slots[i];
			model_count--;
		end
		r.fill = 5'(model_count);
		return r;
	endfunction

	task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	// input beats: predict and queue the result
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			predicted = apply_queue_op(s_tuser[0], s_tdata[15:0], s_tdata[23:16],
				s_tdata[31:24]);
			awaited_results.push_back(row_fixed ? row_res : predicted);
		end
	end

	// output beats: compare with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				check_field("status", awaited_results[0].status, m_tuser);
				check_field("head_code", awaited_results[0].code, m_tdata[15:0]);
				check_field("head_kind", awaited_results[0].kind, m_tdata[23:16]);
				check_field("head_priority", awaited_results[0].prio, m_tdata[31:24]);
				check_field("fill_count", awaited_results[0].fill, m_tdata[36:32]);
				void'(awaited_results.pop_front());
			end
		end
	end

	// receiver: random hold-off per beat (none while no_idle), one long hold-off on request
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 3);
			if (long_stall_req) begin
				gap = LONG_STALL;
				long_stall_req = 1'b0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// sender: offer one beat after a random gap (none while no_idle), return at the next falling edge
	task automatic send_beat(logic cmd, logic [15:0] code, logic [7:0] kind,
			logic [7:0] prio, logic fixed, queue_res_t res);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_fixed = fixed;
		row_res   = res;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {prio, kind, code};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// sender pause: hold off until every expected result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (awaited_results.size() != 0);
	endtask

	initial begin
		logic        cmd;
		logic [7:0]  prio;
		int          ins_pct;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		arst_n   = 1'b0;

		// empty and extreme entries, ignored fields on pop, then fill past full
		dir_rows = '{
			'{CMD_POP,    16'h0000, 8'h00, 8'h00, 1'b1, '{ST_EMPTY, 16'h0, 8'h0, 8'h0, 5'd0}},
			'{CMD_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, '{ST_INSERTED, 16'h0, 8'h0, 8'h0, 5'd1}},
			'{CMD_INSERT, 16'h0000, 8'h00, 8'h00, 1'b1, '{ST_INSERTED, 16'h0, 8'h0, 8'h0, 5'd2}},
			'{CMD_POP,    16'h0000, 8'h00, 8'h00, 1'b1, '{ST_POPPED, 16'h0, 8'h0, 8'h0, 5'd1}},
			'{CMD_POP,    16'h0000, 8'h00, 8'h00, 1'b1,
				'{ST_POPPED, 16'hFFFF, 8'hFF, 8'hFF, 5'd0}},
			'{CMD_POP,    16'hA5A5, 8'h5A, 8'hC3, 1'b1, '{ST_EMPTY, 16'h0, 8'h0, 8'h0, 5'd0}},
			'{CMD_INSERT, 16'h1001, 8'h01, 8'h05, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h1002, 8'h02, 8'h05, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h1003, 8'h03, 8'h03, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h1004, 8'h04, 8'h05, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h1005, 8'h05, 8'hFF, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h1006, 8'h06, 8'h00, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h1007, 8'h07, 8'h03, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h1008, 8'h08, 8'hFF, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h1009, 8'h09, 8'h80, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h100A, 8'h0A, 8'h05, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h100B, 8'h0B, 8'h00, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h100C, 8'h0C, 8'h7F, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h100D, 8'h0D, 8'h80, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h100E, 8'h0E, 8'h01, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h100F, 8'h0F, 8'hFE, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h1010, 8'h10, 8'h05, 1'b0, NO_RES},
			'{CMD_INSERT, 16'h5555, 8'hAA, 8'h00, 1'b1, '{ST_FULL, 16'h0, 8'h0, 8'h0, 5'd16}},
			'{CMD_POP,    16'h0000, 8'h00, 8'h00, 1'b0, NO_RES},
			'{CMD_INSERT, 16'hC0DE, 8'h77, 8'h00, 1'b0, NO_RES}
		};

		// reset once at the start
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_rows[i])
			send_beat(dir_rows[i].cmd, dir_rows[i].code, dir_rows[i].kind,
				dir_rows[i].prio, dir_rows[i].fixed, dir_rows[i].res);
		drain_results();

		// random phases: fill-heavy, drain-heavy, balanced; narrow priorities in odd phases give ties
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			case (seg % 3)
				0: ins_pct = 75;
				1: ins_pct = 25;
				default: ins_pct = 50;
			endcase
			no_idle = (seg == 7);
			if (seg == 4)
				long_stall_req = 1'b1;
			for (int n = 0; n < SEG_ITEMS; n++) begin
				cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_POP;
				if (seg % 2 == 0)
					prio = 8'($urandom_range(0, 255));
				else if ($urandom_range(0, 15) == 0)
					prio = 8'hFF;
				else
					prio = 8'($urandom_range(0, 7));
				send_beat(cmd, 16'($urandom), 8'($urandom_range(0, 255)), prio,
					1'b0, NO_RES);
			end
			drain_results();
		end
		no_idle = 1'b0;

		// let the block settle, then report
		repeat (20) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("tb_stable_priority_queue: done, clean");
		else
			$display("tb_stable_priority_queue: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("tb_stable_priority_queue: done, errors");
		$finish;
	end

endmodule
